[src/sts_pkg.sv]
// Shared types and constants of the source token scanner.
package sts_pkg;

  typedef enum logic [9:0] {
    MODE_IDLE    = 10'b0000000001,
    MODE_INT     = 10'b0000000010,
    MODE_WORD    = 10'b0000000100,
    MODE_EQ      = 10'b0000001000,
    MODE_BANG    = 10'b0000010000,
    MODE_LT      = 10'b0000100000,
    MODE_GT      = 10'b0001000000,
    MODE_SLASH   = 10'b0010000000,
    MODE_COMMENT = 10'b0100000000,
    MODE_HALT    = 10'b1000000000
  } scan_mode_e;

  localparam logic [5:0] KIND_LET      = 6'd0;
  localparam logic [5:0] KIND_FN       = 6'd1;
  localparam logic [5:0] KIND_INT      = 6'd2;
  localparam logic [5:0] KIND_BOOL     = 6'd3;
  localparam logic [5:0] KIND_VOID     = 6'd4;
  localparam logic [5:0] KIND_WHILE    = 6'd5;
  localparam logic [5:0] KIND_IF       = 6'd6;
  localparam logic [5:0] KIND_ELSE     = 6'd7;
  localparam logic [5:0] KIND_RETURN   = 6'd8;
  localparam logic [5:0] KIND_BOOL_LIT = 6'd9;
  localparam logic [5:0] KIND_IDENT    = 6'd10;
  localparam logic [5:0] KIND_INT_LIT  = 6'd11;
  localparam logic [5:0] KIND_ASSIGN   = 6'd12;
  localparam logic [5:0] KIND_EQ_EQ    = 6'd13;
  localparam logic [5:0] KIND_BANG     = 6'd14;
  localparam logic [5:0] KIND_NOT_EQ   = 6'd15;
  localparam logic [5:0] KIND_LT       = 6'd16;
  localparam logic [5:0] KIND_LT_EQ    = 6'd17;
  localparam logic [5:0] KIND_GT       = 6'd18;
  localparam logic [5:0] KIND_GT_EQ    = 6'd19;
  localparam logic [5:0] KIND_SLASH    = 6'd20;
  localparam logic [5:0] KIND_PLUS     = 6'd21;
  localparam logic [5:0] KIND_MINUS    = 6'd22;
  localparam logic [5:0] KIND_STAR     = 6'd23;
  localparam logic [5:0] KIND_COLON    = 6'd24;
  localparam logic [5:0] KIND_SEMI     = 6'd25;
  localparam logic [5:0] KIND_COMMA    = 6'd26;
  localparam logic [5:0] KIND_LPAREN   = 6'd27;
  localparam logic [5:0] KIND_RPAREN   = 6'd28;
  localparam logic [5:0] KIND_LBRACE   = 6'd29;
  localparam logic [5:0] KIND_RBRACE   = 6'd30;
  localparam logic [5:0] KIND_END      = 6'd31;
  localparam logic [5:0] KIND_ERROR    = 6'd32;
  localparam logic [5:0] KIND_NONE     = 6'd63;

  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Classification of one byte, made in the front stage.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
    logic       is_space;
    logic       is_digit;
    logic       is_alpha;
    logic       is_lf;
    logic       is_eq;
    logic       is_slash;
    logic [5:0] single;  // single-byte token kind, KIND_NONE if none
  } byte_class_t;

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+": k = KIND_PLUS;
      "-": k = KIND_MINUS;
      "*": k = KIND_STAR;
      ":": k = KIND_COLON;
      ";": k = KIND_SEMI;
      ",": k = KIND_COMMA;
      "(": k = KIND_LPAREN;
      ")": k = KIND_RPAREN;
      "{": k = KIND_LBRACE;
      "}": k = KIND_RBRACE;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] classify_word(input logic [47:0] w, input logic [2:0] n);
    logic [5:0] k;
    k = KIND_IDENT;
    case (n)
      3'd2: begin
        if (w[15:0] == {"n", "f"}) k = KIND_FN;
        else if (w[15:0] == {"f", "i"}) k = KIND_IF;
      end
      3'd3: begin
        if (w[23:0] == {"t", "e", "l"}) k = KIND_LET;
        else if (w[23:0] == {"t", "n", "i"}) k = KIND_INT;
      end
      3'd4: begin
        if (w[31:0] == {"l", "o", "o", "b"}) k = KIND_BOOL;
        else if (w[31:0] == {"d", "i", "o", "v"}) k = KIND_VOID;
        else if (w[31:0] == {"e", "s", "l", "e"}) k = KIND_ELSE;
        else if (w[31:0] == {"e", "u", "r", "t"}) k = KIND_BOOL_LIT;
      end
      3'd5: begin
        if (w[39:0] == {"e", "l", "i", "h", "w"}) k = KIND_WHILE;
        else if (w[39:0] == {"e", "s", "l", "a", "f"}) k = KIND_BOOL_LIT;
      end
      3'd6: begin
        if (w == {"n", "r", "u", "t", "e", "r"}) k = KIND_RETURN;
      end
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

[src/sts_front.sv]
// Front stage: accepts source bytes, classifies them and feeds a two-entry queue.
module sts_front
  import sts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  source_byte_i,
  input  logic        end_marker_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output byte_class_t q_data_o
);

  byte_class_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  byte_class_t cls;
  logic        push;

  always_comb begin
    cls          = '0;
    cls.ch       = source_byte_i;
    cls.is_end   = end_marker_i || (source_byte_i == 8'd0);
    cls.is_space = (source_byte_i == " ") || (source_byte_i == 8'h09) ||
                   (source_byte_i == CHAR_LF) || (source_byte_i == 8'h0D);
    cls.is_digit = (source_byte_i >= "0") && (source_byte_i <= "9");
    cls.is_alpha = ((source_byte_i >= "a") && (source_byte_i <= "z")) ||
                   ((source_byte_i >= "A") && (source_byte_i <= "Z")) ||
                   (source_byte_i == "_");
    cls.is_lf    = (source_byte_i == CHAR_LF);
    cls.is_eq    = (source_byte_i == "=");
    cls.is_slash = (source_byte_i == "/");
    cls.single   = single_kind(source_byte_i);
  end

  assign ready_o   = (count_q != 2'd2);
  assign push      = valid_i && ready_o;
  assign q_valid_o = (count_q != 2'd0);
  assign q_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

[src/sts_back.sv]
// Back stage: scanning state machine and token emission through a two-slot output buffer.
module sts_back
  import sts_pkg::*;
#(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  byte_class_t            q_data_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [5:0]             token_kind_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [OFFSET_BITS-1:0] token_length_o,
  output logic [LINE_BITS-1:0]   start_line_o,
  output logic [COLUMN_BITS-1:0] start_column_o,
  output logic                   last_of_run_o
);

  localparam logic [OFFSET_BITS-1:0] OffMax = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LineMax = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] ColMax = {COLUMN_BITS{1'b1}};

  typedef struct packed {
    logic [5:0]             kind;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic                   last;
  } tok_t;

  scan_mode_e             mode_q, mode_d;
  logic [OFFSET_BITS-1:0] off_q, off_d, toff_q, toff_d, cnt_q, cnt_d;
  logic [LINE_BITS-1:0]   line_q, line_d, tline_q, tline_d;
  logic [COLUMN_BITS-1:0] col_q, col_d, tcol_q, tcol_d;
  logic [7:0]             wbuf_q [6];
  logic [2:0]             wlen_q, wlen_d;
  logic                   wwr;
  logic [2:0]             wwr_idx;

  tok_t  t0, t1;
  logic  e0, e1;
  tok_t  slot_q [2];
  logic  rd_q, wr_q;
  logic [1:0] cnt_out_q;
  logic  step;
  logic [47:0] wflat;

  byte_class_t c;
  assign c = q_data_i;

  // Only step when the output buffer can take two tokens.
  assign step    = q_valid_i && (cnt_out_q == 2'd0 ||
                   (cnt_out_q == 2'd1 && ready_i));
  assign q_pop_o = step;

  always_comb begin
    for (int i = 0; i < 6; i++) wflat[i*8 +: 8] = wbuf_q[i];
  end

  function automatic tok_t mk(input logic [5:0] k, input logic [OFFSET_BITS-1:0] o,
                              input logic [OFFSET_BITS-1:0] l,
                              input logic [LINE_BITS-1:0] ln,
                              input logic [COLUMN_BITS-1:0] cl);
    tok_t t;
    t.kind = k; t.off = o; t.len = l; t.line = ln; t.col = cl; t.last = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [5:0] pk;
    logic       fresh;
    logic       adv;
    pk = KIND_NONE;
    unique case (mode_q)
      MODE_INT:   pk = KIND_INT_LIT;
      MODE_WORD:  pk = classify_word(wflat, wlen_q);
      MODE_EQ:    pk = KIND_ASSIGN;
      MODE_BANG:  pk = KIND_BANG;
      MODE_LT:    pk = KIND_LT;
      MODE_GT:    pk = KIND_GT;
      MODE_SLASH: pk = KIND_SLASH;
      default:    pk = KIND_NONE;
    endcase
    mode_d = mode_q; off_d = off_q; line_d = line_q; col_d = col_q;
    toff_d = toff_q; tline_d = tline_q; tcol_d = tcol_q; cnt_d = cnt_q;
    wlen_d = wlen_q; wwr = 1'b0; wwr_idx = wlen_q;
    e0 = 1'b0; e1 = 1'b0;
    t0 = mk(pk, toff_q, cnt_q, tline_q, tcol_q);
    t1 = t0;
    fresh = 1'b0; adv = 1'b0;
    if (c.is_end) begin
      if (pk != KIND_NONE) e0 = 1'b1;
      t1 = mk(KIND_END, off_q, '0, line_q, col_q);
      e1 = 1'b1;
      mode_d = MODE_IDLE; off_d = '0; line_d = LINE_BITS'(1); col_d = COLUMN_BITS'(1);
      toff_d = '0; tline_d = LINE_BITS'(1); tcol_d = COLUMN_BITS'(1);
      cnt_d = '0; wlen_d = '0;
    end else begin
      unique case (mode_q)
        MODE_HALT: ;
        MODE_COMMENT: begin
          if (c.is_lf) mode_d = MODE_IDLE;
          adv = 1'b1;
        end
        MODE_INT: begin
          if (c.is_digit) begin
            cnt_d = (cnt_q == OffMax) ? cnt_q : cnt_q + 1'b1;
            adv = 1'b1;
          end else begin
            e0 = 1'b1; fresh = 1'b1;
          end
        end
        MODE_WORD: begin
          if (c.is_alpha || c.is_digit) begin
            wwr = (wlen_q < 3'd6);
            if (wlen_q != 3'd7) wlen_d = wlen_q + 3'd1;
            cnt_d = (cnt_q == OffMax) ? cnt_q : cnt_q + 1'b1;
            adv = 1'b1;
          end else begin
            e0 = 1'b1; fresh = 1'b1;
          end
        end
        MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
          if (c.is_eq) begin
            e0 = 1'b1;
            t0.kind = pk + 6'd1;
            t0.len = (cnt_q == OffMax) ? cnt_q : cnt_q + 1'b1;
            mode_d = MODE_IDLE;
            adv = 1'b1;
          end else begin
            e0 = 1'b1; fresh = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c.is_slash) begin
            mode_d = MODE_COMMENT; adv = 1'b1;
          end else begin
            e0 = 1'b1; fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase
      if (fresh) begin
        mode_d = MODE_IDLE;
        adv = 1'b1;
        if (!c.is_space) begin
          toff_d = off_q; tline_d = line_q; tcol_d = col_q; cnt_d = OFFSET_BITS'(1);
          if (c.is_digit) mode_d = MODE_INT;
          else if (c.is_alpha) begin
            mode_d = MODE_WORD; wwr = 1'b1; wwr_idx = 3'd0; wlen_d = 3'd1;
          end else if (c.is_eq) mode_d = MODE_EQ;
          else if (c.ch == "!") mode_d = MODE_BANG;
          else if (c.ch == "<") mode_d = MODE_LT;
          else if (c.ch == ">") mode_d = MODE_GT;
          else if (c.is_slash) mode_d = MODE_SLASH;
          else begin
            t1 = mk((c.single != KIND_NONE) ? c.single : KIND_ERROR, off_q,
                    OFFSET_BITS'(1), line_q, col_q);
            e1 = 1'b1;
            if (c.single == KIND_NONE) mode_d = MODE_HALT;
          end
        end
      end
      if (adv) begin
        off_d = (off_q == OffMax) ? off_q : off_q + 1'b1;
        if (c.is_lf) begin
          line_d = (line_q == LineMax) ? line_q : line_q + 1'b1;
          col_d  = COLUMN_BITS'(1);
        end else begin
          col_d = (col_q == ColMax) ? col_q : col_q + 1'b1;
        end
      end
    end
    if (e1) t1.last = 1'b1;
    else t0.last = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (step && wwr) wbuf_q[wwr_idx] <= c.ch;
  end

  // Output buffer: two slots, each step may write none, one or two.
  logic pop_out;
  assign pop_out = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (step) begin
      if (e0) slot_q[wr_q] <= t0;
      if (e1) slot_q[wr_q ^ e0] <= t1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      off_q <= '0; line_q <= LINE_BITS'(1); col_q <= COLUMN_BITS'(1);
      toff_q <= '0; tline_q <= LINE_BITS'(1); tcol_q <= COLUMN_BITS'(1);
      cnt_q <= '0; wlen_q <= '0;
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_out_q <= 2'd0;
    end else begin
      if (step) begin
        mode_q <= mode_d; off_q <= off_d; line_q <= line_d; col_q <= col_d;
        toff_q <= toff_d; tline_q <= tline_d; tcol_q <= tcol_d;
        cnt_q <= cnt_d; wlen_q <= wlen_d;
        wr_q <= wr_q ^ (e0 ^ e1);
      end
      if (pop_out) rd_q <= ~rd_q;
      cnt_out_q <= cnt_out_q + (step ? {1'b0, e0} + {1'b0, e1} : 2'd0)
                   - {1'b0, pop_out};
    end
  end

  tok_t head;
  assign head           = slot_q[rd_q];
  assign valid_o        = (cnt_out_q != 2'd0);
  assign token_kind_o   = head.kind;
  assign start_offset_o = head.off;
  assign token_length_o = head.len;
  assign start_line_o   = head.line;
  assign start_column_o = head.col;
  assign last_of_run_o  = head.last;

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_out_q != 2'd3) else $error("output buffer overflow");
  a_two_only_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && e0 && e1) |-> (c.is_end || t1.kind != KIND_END))
    else $error("two tokens from one byte without cause");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_HALT && step && !c.is_end) |=> mode_q == MODE_HALT)
    else $error("left halt without end");
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0 && col_q != '0) else $error("line or column zero");

endmodule

[src/source_token_scanner_core.sv]
// Top level of the source token scanner.
// The scanner takes one source byte per transfer and produces up to two token transfers
// per byte, each with kind, start offset, length, line and column; last_of_run_o marks the
// final token caused by a byte. A front stage classifies each byte into a two-entry queue,
// and a back stage runs the scanning state machine and writes tokens into a two-slot
// output buffer. Sustained rate is one byte per cycle while ready_i stays high and each
// byte yields at most one token; a byte yielding two tokens (a flushed token and then a
// single-character or end token) holds up input while the output port sends them singly.
// Whitespace and comment bytes give no token. There is no clearing pass after reset.
module source_token_scanner_core
  import sts_pkg::*;
#(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [7:0]             source_byte_i,
  input  logic                   end_marker_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [5:0]             token_kind_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [OFFSET_BITS-1:0] token_length_o,
  output logic [LINE_BITS-1:0]   start_line_o,
  output logic [COLUMN_BITS-1:0] start_column_o,
  output logic                   last_of_run_o
);

  // Queue between the front and back stages.
  logic        q_valid, q_pop;
  byte_class_t q_data;

  sts_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .source_byte_i, .end_marker_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  sts_back #(
    .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)
  ) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .valid_o, .ready_i, .token_kind_o, .start_offset_o, .token_length_o,
    .start_line_o, .start_column_o, .last_of_run_o
  );

endmodule

[test/source_token_scanner_core_tb.sv]
// Self-checking testbench of the source token scanner with random handshake idling.
module source_token_scanner_core_tb
  import sts_pkg::*;
();

  localparam int OffW = 24;
  localparam int LineW = 20;
  localparam int ColW = 16;
  localparam logic [OffW-1:0] OffMax = '1;
  localparam logic [LineW-1:0] LineMax = '1;
  localparam logic [ColW-1:0] ColMax = '1;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } src_item_t;

  typedef struct packed {
    logic [5:0]       kind;
    logic [OffW-1:0]  offset;
    logic [OffW-1:0]  length;
    logic [LineW-1:0] line;
    logic [ColW-1:0]  column;
    logic             last;
  } token_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_byte;
  logic             in_end;
  logic             out_valid;
  logic             out_ready;
  logic [5:0]       out_kind;
  logic [OffW-1:0]  out_offset;
  logic [OffW-1:0]  out_length;
  logic [LineW-1:0] out_line;
  logic [ColW-1:0]  out_column;
  logic             out_last;

  source_token_scanner_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .valid_i       (in_valid),
    .ready_o       (in_ready),
    .source_byte_i (in_byte),
    .end_marker_i  (in_end),
    .valid_o       (out_valid),
    .ready_i       (out_ready),
    .token_kind_o  (out_kind),
    .start_offset_o(out_offset),
    .token_length_o(out_length),
    .start_line_o  (out_line),
    .start_column_o(out_column),
    .last_of_run_o (out_last)
  );

  // Scanner state kept by the predictor, in the package's mode encoding.
  scan_mode_e       mode;
  logic [OffW-1:0]  cur_off;
  logic [LineW-1:0] cur_line;
  logic [ColW-1:0]  cur_col;
  logic [OffW-1:0]  tok_off;
  logic [LineW-1:0] tok_line;
  logic [ColW-1:0]  tok_col;
  logic [OffW-1:0]  tok_len;
  logic [7:0]       word [6];
  int               word_len;

  src_item_t pending_bytes[$];
  token_t    expected_tokens[$];
  token_t    step_tokens[$];
  int        mismatches;
  int        tokens_seen;
  int        cycles;
  bit        stim_done;
  int        hold_off;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || c == 8'h09 || c == CHAR_LF || c == 8'h0D;
  endfunction

  function automatic logic [5:0] punct_kind(logic [7:0] c);
    case (c)
      "+": return KIND_PLUS;
      "-": return KIND_MINUS;
      "*": return KIND_STAR;
      ":": return KIND_COLON;
      ";": return KIND_SEMI;
      ",": return KIND_COMMA;
      "(": return KIND_LPAREN;
      ")": return KIND_RPAREN;
      "{": return KIND_LBRACE;
      "}": return KIND_RBRACE;
      default: return KIND_NONE;
    endcase
  endfunction

  function automatic bit word_is(string s);
    if (s.len() != word_len) return 0;
    for (int i = 0; i < word_len; i++) if (word[i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic logic [5:0] word_kind();
    if (word_len > 6) return KIND_IDENT;
    if (word_is("let")) return KIND_LET;
    if (word_is("fn")) return KIND_FN;
    if (word_is("int")) return KIND_INT;
    if (word_is("bool")) return KIND_BOOL;
    if (word_is("void")) return KIND_VOID;
    if (word_is("while")) return KIND_WHILE;
    if (word_is("if")) return KIND_IF;
    if (word_is("else")) return KIND_ELSE;
    if (word_is("return")) return KIND_RETURN;
    if (word_is("true") || word_is("false")) return KIND_BOOL_LIT;
    return KIND_IDENT;
  endfunction

  task automatic clear_scanner();
    mode = MODE_IDLE;
    cur_off = '0;
    cur_line = LineW'(1);
    cur_col = ColW'(1);
    tok_off = '0;
    tok_line = LineW'(1);
    tok_col = ColW'(1);
    tok_len = '0;
    word_len = 0;
  endtask

  task automatic push_token(logic [5:0] k, logic [OffW-1:0] o, logic [OffW-1:0] l,
                            logic [LineW-1:0] ln, logic [ColW-1:0] c);
    token_t t;
    t = '{kind: k, offset: o, length: l, line: ln, column: c, last: 1'b0};
    step_tokens.insert(step_tokens.size(), t);
  endtask

  task automatic queue_byte(logic [7:0] ch, logic fin);
    src_item_t it;
    it.ch = ch;
    it.fin = fin;
    pending_bytes.insert(pending_bytes.size(), it);
  endtask

  task automatic advance_pos(logic [7:0] c);
    if (cur_off != OffMax) cur_off++;
    if (c == CHAR_LF) begin
      if (cur_line != LineMax) cur_line++;
      cur_col = ColW'(1);
    end else if (cur_col != ColMax) begin
      cur_col++;
    end
  endtask

  // Emits whatever token is waiting for its next byte, then returns to idle.
  task automatic flush_pending();
    logic [5:0] k;
    k = KIND_NONE;
    case (mode)
      MODE_INT:   k = KIND_INT_LIT;
      MODE_WORD:  k = word_kind();
      MODE_EQ:    k = KIND_ASSIGN;
      MODE_BANG:  k = KIND_BANG;
      MODE_LT:    k = KIND_LT;
      MODE_GT:    k = KIND_GT;
      MODE_SLASH: k = KIND_SLASH;
      default: ;
    endcase
    if (k != KIND_NONE) push_token(k, tok_off, tok_len, tok_line, tok_col);
    mode = MODE_IDLE;
  endtask

  task automatic open_token(logic [7:0] c);
    logic [5:0] k;
    if (is_blank(c)) begin
      advance_pos(c);
      return;
    end
    tok_off = cur_off;
    tok_line = cur_line;
    tok_col = cur_col;
    tok_len = OffW'(1);
    if (is_digit(c)) mode = MODE_INT;
    else if (is_alpha(c)) begin
      word[0] = c;
      word_len = 1;
      mode = MODE_WORD;
    end else if (c == "=") mode = MODE_EQ;
    else if (c == "!") mode = MODE_BANG;
    else if (c == "<") mode = MODE_LT;
    else if (c == ">") mode = MODE_GT;
    else if (c == "/") mode = MODE_SLASH;
    else begin
      k = punct_kind(c);
      if (k != KIND_NONE) push_token(k, tok_off, tok_len, tok_line, tok_col);
      else begin
        push_token(KIND_ERROR, tok_off, tok_len, tok_line, tok_col);
        mode = MODE_HALT;
      end
    end
    advance_pos(c);
  endtask

  task automatic predict_tokens(src_item_t it);
    token_t t;
    step_tokens.delete();
    if (it.fin || it.ch == 8'h00) begin
      if (mode != MODE_HALT) flush_pending();
      push_token(KIND_END, cur_off, '0, cur_line, cur_col);
      clear_scanner();
    end else begin
      case (mode)
        MODE_HALT: ;
        MODE_COMMENT: begin
          if (it.ch == CHAR_LF) mode = MODE_IDLE;
          advance_pos(it.ch);
        end
        MODE_INT, MODE_WORD: begin
          if (is_digit(it.ch) || (mode == MODE_WORD && is_alpha(it.ch))) begin
            if (mode == MODE_WORD) begin
              if (word_len < 6) word[word_len] = it.ch;
              if (word_len < 7) word_len++;
            end
            if (tok_len != OffMax) tok_len++;
            advance_pos(it.ch);
          end else begin
            flush_pending();
            open_token(it.ch);
          end
        end
        MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
          if (it.ch == "=") begin
            if (tok_len != OffMax) tok_len++;
            push_token(mode == MODE_EQ ? KIND_EQ_EQ : mode == MODE_BANG ? KIND_NOT_EQ :
                       mode == MODE_LT ? KIND_LT_EQ : KIND_GT_EQ,
                       tok_off, tok_len, tok_line, tok_col);
            mode = MODE_IDLE;
            advance_pos(it.ch);
          end else begin
            flush_pending();
            open_token(it.ch);
          end
        end
        MODE_SLASH: begin
          if (it.ch == "/") begin
            mode = MODE_COMMENT;
            advance_pos(it.ch);
          end else begin
            flush_pending();
            open_token(it.ch);
          end
        end
        default: begin
          mode = MODE_IDLE;
          open_token(it.ch);
        end
      endcase
    end
    for (int i = 0; i < step_tokens.size(); i++) begin
      t = step_tokens[i];
      t.last = (i == step_tokens.size() - 1);
      expected_tokens.insert(expected_tokens.size(), t);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
  endtask

  task automatic add_end(bit by_zero);
    queue_byte(by_zero ? 8'h00 : 8'($urandom), !by_zero);
  endtask

  // Random fragment of mostly well-formed source text.
  task automatic add_fragment();
    string words [12];
    string ops [16];
    int n;
    words = '{"let", "fn", "int", "bool", "void", "while", "if", "else", "return",
              "true", "false", "x_9"};
    ops = '{"=", "==", "!", "!=", "<", "<=", ">", ">=", "/", "+", "-", "*", ":", ";",
            ",", "()"};
    case ($urandom_range(0, 11))
      0, 1: add_text(words[$urandom_range(0, 11)]);
      2: begin
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++)
          queue_byte($urandom_range(0, 1) ? 8'($urandom_range("a", "z")) :
                     8'($urandom_range("0", "9")), 1'b0);
      end
      3: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          queue_byte(8'($urandom_range("0", "9")), 1'b0);
      end
      4, 5: add_text(ops[$urandom_range(0, 15)]);
      6: add_text($urandom_range(0, 1) ? "{}" : "_A");
      7: add_text($urandom_range(0, 1) ? " " : "\n");
      8: add_text($urandom_range(0, 1) ? "\t" : "\r");
      9: begin
        add_text("// c");
        if ($urandom_range(0, 3) != 0) add_text("\n");
      end
      10: queue_byte(8'($urandom_range(1, 255)), 1'b0);
      default: add_text(" ");
    endcase
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = '0;
    in_end = 1'b0;
    out_ready = 1'b0;
    mismatches = 0;
    tokens_seen = 0;
    cycles = 0;
    stim_done = 0;
    hold_off = 0;
    clear_scanner();

    // Directed part: every keyword, both literals, every operator but a lone >, the two-byte
    // operators, a comment, a long word, an error and the freeze after it.
    add_text("let fn int bool void while if else return true false");
    add_end(0);
    add_text("ab_c123x==!=<=>=!<>=/+-*:;,(){}\n1234 //x\n");
    add_end(1);
    add_text("w@z");
    add_end(1);
    add_text("= \x80");
    add_end(0);
    add_text("//x");
    add_end(0);
    add_end(1);

    while (pending_bytes.size() < 1300) begin
      add_fragment();
      if ($urandom_range(0, 40) == 0) add_end($urandom_range(0, 1));
    end
    add_end(1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender: offers the queued bytes with random gaps between transfers.
  int        send_gap;
  src_item_t cur_item;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_tokens(cur_item);
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (pending_bytes.size() == 0) stim_done <= 1'b1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && pending_bytes.size() != 0) begin
          cur_item = pending_bytes.pop_front();
          in_byte <= cur_item.ch;
          in_end <= cur_item.fin;
          in_valid <= 1'b1;
        end else begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the scanner back-pressures.
  int recv_gap;
  always @(posedge clk) begin
    if (rst_n) begin
      cycles++;
      if (cycles == 300) hold_off = 200;
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token kind %0d", out_kind);
        end else begin
          token_t e;
          token_t a;
          e = expected_tokens.pop_front();
          a = '{kind: out_kind, offset: out_offset, length: out_length, line: out_line,
                column: out_column, last: out_last};
          if (a !== e) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("token mismatch: exp k%0d o%0d l%0d ln%0d c%0d e%0b",
                       e.kind, e.offset, e.length, e.line, e.column, e.last);
              $display("                got k%0d o%0d l%0d ln%0d c%0d e%0b",
                       a.kind, a.offset, a.length, a.line, a.column, a.last);
            end
          end
        end
        tokens_seen++;
        recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (rst_n);
    fork
      begin
        wait (stim_done && expected_tokens.size() == 0);
        repeat (20) @(posedge clk);
      end
      begin
        wait (cycles >= CycleLimit);
        $display("timeout after %0d cycles", cycles);
        $display("source_token_scanner_core test failed");
        $finish;
      end
    join_any
    $display("Scanned over 1300 source bytes with keywords, operators, comments and errors;");
    $display("%0d tokens were compared, %0d mismatched.", tokens_seen, mismatches);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("source_token_scanner_core test passed");
    end else begin
      $display("source_token_scanner_core test failed");
    end
    $finish;
  end

endmodule
